>>> src/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared widths, constants and register codes of the proxemic cost cell.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int FRAC_BITS_DEF = 10;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int REL_W   = 18;
    localparam int VEL_W   = 16;
    localparam int COST_W  = 8;
    localparam int COV_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int MAG_W   = 16;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int PRJ_W   = 34;
    localparam int R2_W    = 36;
    localparam int AXIS_W  = 20;
    localparam int AXSQ_W  = 2 * AXIS_W;
    localparam int FA_W    = 34;
    localparam int FA_LO_W = 17;
    localparam int DENA_W  = COV_W + FA_W;
    localparam int NUMA_W  = AXSQ_W + 23;
    localparam int NUMB_W  = AXSQ_W + 15;
    localparam int EQ_W    = 21;
    localparam int E_W     = EQ_W + 1;
    localparam int X_W     = 30;
    localparam int M_W     = 31;

    localparam logic [30:0]    LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0]    LN2_Q30   = 30'd744261118;
    localparam logic [M_W-1:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [E_W-1:0] E_LIMIT   = 22'h20_0000;

    localparam logic [7:0]  AMPLITUDE_RST  = 8'd77;
    localparam logic [7:0]  CUTOFF_RST     = 8'd10;
    localparam logic [15:0] COVARIANCE_RST = 16'd256;
    localparam logic [15:0] SPEED_GAIN_RST = 16'd1280;
    localparam logic        ENABLED_RST    = 1'b1;

    localparam logic [COST_W-1:0] COST_UNKNOWN = 8'd255;

    typedef enum logic [2:0] {
        REG_AMPLITUDE  = 3'd0,
        REG_CUTOFF     = 3'd1,
        REG_COVARIANCE = 3'd2,
        REG_SPEED_GAIN = 3'd3,
        REG_ENABLED    = 3'd4
    } reg_idx_t;

endpackage

>>> src/pcc_isqrt.sv
// ----------------------------------------------------------------------------
// pcc_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pcc_isqrt
    import pcc_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [SQ_W-1:0]   rad,
    input  logic [SIDE_W-1:0] side_in,
    output logic [MAG_W-1:0]  root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int REM_W = MAG_W + 1;

    logic [REM_W-1:0]  rem_reg  [1:MAG_W];
    logic [MAG_W-1:0]  root_reg [1:MAG_W];
    logic [SQ_W-1:0]   rad_reg  [1:MAG_W];
    logic [SIDE_W-1:0] side_reg [1:MAG_W];

    genvar i;
    generate
        for (i = 0; i < MAG_W; i++)
        begin : g_stage
            localparam int PB = 2 * (MAG_W - 1 - i);
            logic [REM_W-1:0]  rem_prev;
            logic [MAG_W-1:0]  root_prev;
            logic [SQ_W-1:0]   rad_prev;
            logic [SIDE_W-1:0] side_prev;
            logic [REM_W+1:0]  sh;
            logic [REM_W+1:0]  trial;
            logic              ge;
            logic [REM_W+1:0]  diff;

            if (i == 0)
            begin : g_first
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign rad_prev  = rad;
                assign side_prev = side_in;
            end
            else
            begin : g_next
                assign rem_prev  = rem_reg[i];
                assign root_prev = root_reg[i];
                assign rad_prev  = rad_reg[i];
                assign side_prev = side_reg[i];
            end

            assign sh    = {rem_prev, rad_prev[PB+1:PB]};
            assign trial = (REM_W+2)'({root_prev, 2'b01});
            assign ge    = (sh >= trial);
            assign diff  = sh - trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[i+1] <= '0;
                end
                else if (en)
                begin
                    side_reg[i+1] <= side_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1]  <= ge ? diff[REM_W-1:0] : sh[REM_W-1:0];
                    root_reg[i+1] <= {root_prev[MAG_W-2:0], ge};
                    rad_reg[i+1]  <= rad_prev;
                end
            end
        end
    endgenerate

    assign root     = root_reg[MAG_W];
    assign side_out = side_reg[MAG_W];

endmodule

>>> src/pcc_div.sv
// ----------------------------------------------------------------------------
// pcc_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees num < den << Q_W, or ignores the quotient.
// ----------------------------------------------------------------------------
module pcc_div
    import pcc_pkg::*;
#(
    parameter int N_W    = 34,
    parameter int D_W    = 16,
    parameter int Q_W    = 20,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [N_W-1:0]    num,
    input  logic [D_W-1:0]    den,
    input  logic [SIDE_W-1:0] side_in,
    output logic [Q_W-1:0]    quo,
    output logic [SIDE_W-1:0] side_out
);

    logic [D_W-1:0]    rem_reg  [1:Q_W];
    logic [Q_W-1:0]    quo_reg  [1:Q_W];
    logic [Q_W-1:0]    low_reg  [1:Q_W];
    logic [D_W-1:0]    den_reg  [1:Q_W];
    logic [SIDE_W-1:0] side_reg [1:Q_W];

    logic [N_W-Q_W-1:0] num_hi;
    assign num_hi = num[N_W-1:Q_W];

    genvar i;
    generate
        for (i = 0; i < Q_W; i++)
        begin : g_stage
            localparam int B = Q_W - 1 - i;
            logic [D_W-1:0]    rem_prev;
            logic [Q_W-1:0]    quo_prev;
            logic [Q_W-1:0]    low_prev;
            logic [D_W-1:0]    den_prev;
            logic [SIDE_W-1:0] side_prev;
            logic [D_W:0]      sh;
            logic [D_W:0]      diff;
            logic              ge;

            if (i == 0)
            begin : g_first
                assign rem_prev  = D_W'(num_hi);
                assign quo_prev  = '0;
                assign low_prev  = num[Q_W-1:0];
                assign den_prev  = den;
                assign side_prev = side_in;
            end
            else
            begin : g_next
                assign rem_prev  = rem_reg[i];
                assign quo_prev  = quo_reg[i];
                assign low_prev  = low_reg[i];
                assign den_prev  = den_reg[i];
                assign side_prev = side_reg[i];
            end

            assign sh   = {rem_prev, low_prev[B]};
            assign ge   = (sh >= {1'b0, den_prev});
            assign diff = sh - {1'b0, den_prev};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[i+1] <= '0;
                end
                else if (en)
                begin
                    side_reg[i+1] <= side_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1]  <= ge ? diff[D_W-1:0] : sh[D_W-1:0];
                    quo_reg[i+1]  <= quo_prev | (Q_W'(ge) << B);
                    low_reg[i+1]  <= low_prev;
                    den_reg[i+1]  <= den_prev;
                end
            end
        end
    endgenerate

    assign quo      = quo_reg[Q_W];
    assign side_out = side_reg[Q_W];

endmodule

>>> src/pcc_exp.sv
// ----------------------------------------------------------------------------
// pcc_exp
// Pipelined amplitude * exp(-e): base-2 split, then exp(-y) by a nested
// seven-term series, three stages per term.
// ----------------------------------------------------------------------------
module pcc_exp
    import pcc_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [E_W-1:0]    e,
    input  logic [COST_W-1:0] amp,
    input  logic [SIDE_W-1:0] side_in,
    output logic [COST_W-1:0] cost,
    output logic [SIDE_W-1:0] side_out
);

    localparam int TERMS = 7;

    logic [E_W-1:0]    t_reg;
    logic [SIDE_W-1:0] st_reg;
    logic [52:0]       t_prod;

    logic [X_W-1:0]    y0_reg;
    logic [5:0]        n0_reg;
    logic [SIDE_W-1:0] s0_reg;
    logic [45:0]       y_prod;

    logic [X_W-1:0]    y_s  [0:TERMS];
    logic [5:0]        n_s  [0:TERMS];
    logic [M_W-1:0]    m_s  [0:TERMS];
    logic [SIDE_W-1:0] sd_s [0:TERMS];

    assign t_prod = 53'(e) * 53'(LOG2E_Q30);
    assign y_prod = 46'(t_reg[15:0]) * 46'(LN2_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
            s0_reg <= '0;
        end
        else if (en)
        begin
            st_reg <= side_in;
            s0_reg <= st_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg  <= t_prod[51:30];
            y0_reg <= y_prod[45:16];
            n0_reg <= t_reg[21:16];
        end
    end

    assign y_s[0]  = y0_reg;
    assign n_s[0]  = n0_reg;
    assign m_s[0]  = ONE_Q30;
    assign sd_s[0] = s0_reg;

    genvar j;
    generate
        for (j = 0; j < TERMS; j++)
        begin : g_term
            localparam int K = TERMS - j;
            localparam logic [32:0] RECIP = 33'((64'd1 << 32) / K);

            logic [X_W-1:0]    xa_reg, xb_reg, qb_reg;
            logic [X_W-1:0]    ya_reg, yb_reg, yc_reg;
            logic [5:0]        na_reg, nb_reg, nc_reg;
            logic [M_W-1:0]    mc_reg;
            logic [SIDE_W-1:0] sa_reg, sb_reg, sc_reg;
            logic [60:0]       ym_prod;
            logic [62:0]       r_prod;
            logic [32:0]       qk;
            logic [X_W-1:0]    r;
            logic [X_W-1:0]    q;

            assign ym_prod = 61'(y_s[j]) * 61'(m_s[j]);
            assign r_prod  = 63'(xa_reg) * 63'(RECIP);
            assign qk      = 33'(qb_reg) * 33'(K);
            assign r       = xb_reg - qk[X_W-1:0];
            assign q       = qb_reg + X_W'(r >= X_W'(K));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sa_reg <= '0;
                    sb_reg <= '0;
                    sc_reg <= '0;
                end
                else if (en)
                begin
                    sa_reg <= sd_s[j];
                    sb_reg <= sa_reg;
                    sc_reg <= sb_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    xa_reg <= ym_prod[59:30];
                    ya_reg <= y_s[j];
                    na_reg <= n_s[j];
                    qb_reg <= r_prod[61:32];
                    xb_reg <= xa_reg;
                    yb_reg <= ya_reg;
                    nb_reg <= na_reg;
                    mc_reg <= ONE_Q30 - M_W'(q);
                    yc_reg <= yb_reg;
                    nc_reg <= nb_reg;
                end
            end

            assign y_s[j+1]  = yc_reg;
            assign n_s[j+1]  = nc_reg;
            assign m_s[j+1]  = mc_reg;
            assign sd_s[j+1] = sc_reg;
        end
    endgenerate

    logic [38:0]       p_reg;
    logic [5:0]        np_reg;
    logic [SIDE_W-1:0] sp_reg;
    logic [COST_W-1:0] cost_reg;
    logic [SIDE_W-1:0] sq_reg;
    logic [8:0]        p_int;

    assign p_int = p_reg[38:30] >> np_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
            sq_reg <= '0;
        end
        else if (en)
        begin
            sp_reg <= sd_s[TERMS];
            sq_reg <= sp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= 39'(amp) * 39'(m_s[TERMS]);
            np_reg   <= n_s[TERMS];
            cost_reg <= p_int[COST_W-1:0];
        end
    end

    assign cost     = cost_reg;
    assign side_out = sq_reg;

endmodule

>>> src/proxemic_cost_cell.sv
// ----------------------------------------------------------------------------
// proxemic_cost_cell
// Asymmetric Gaussian personal-space cost for one costmap cell.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  request   in         in_valid / in_stall          rel_x rel_y vel_x vel_y
//                                                    reliable prior_cost
//  result    out        out_valid / out_stall        new_cost written
//  config    in         APB psel/penable/pwrite      amplitude cutoff
//                                                    covariance speed_gain enabled
//
//  One request per clock while not stalled; the path runs through the 16-stage
//  square root, the two divider pairs (20 and 21 stages) and the 7-term series.
//  Reset clears all valid bits and loads register defaults; no clearing pass.
//  A stalled result holds every stage; in_stall follows it in the same cycle.
// ----------------------------------------------------------------------------
module proxemic_cost_cell
    import pcc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]        pwdata,
    output logic [DATA_W-1:0]        prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [REL_W-1:0]  rel_x,
    input  logic signed [REL_W-1:0]  rel_y,
    input  logic signed [VEL_W-1:0]  vel_x,
    input  logic signed [VEL_W-1:0]  vel_y,
    input  logic                     reliable,
    input  logic [COST_W-1:0]        prior_cost,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [COST_W-1:0]        new_cost,
    output logic                     written
);

    localparam int DENB_W = COV_W + FRAC_BITS;
    localparam int CMPA_W = DENA_W + EQ_W;
    localparam int CMPB_W = (NUMB_W > DENB_W + EQ_W) ? NUMB_W : DENB_W + EQ_W;
    localparam logic [FA_W-1:0] FA_BASE = FA_W'(1) << (FRAC_BITS + 8);

    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] old;
        logic              rel;
        logic              sz;
        logic              pos;
        logic              ry_neg;
        logic [REL_W-1:0]  abs_rx;
        logic [REL_W-1:0]  abs_ry;
        logic [R2_W-1:0]   r2;
        logic [PRJ_W-1:0]  ap;
        logic [PRJ_W-1:0]  aq;
    } sqrt_ctx_t;

    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] old;
        logic              rel;
        logic              sz;
        logic              pos;
        logic              ry_neg;
        logic [MAG_W-1:0]  mag;
        logic [REL_W-1:0]  abs_rx;
        logic [REL_W-1:0]  abs_ry;
    } proj_ctx_t;

    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] old;
        logic              ova;
    } expo_ctx_t;

    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] old;
    } tail_ctx_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  amplitude_reg;
    logic [7:0]  cutoff_reg;
    logic [15:0] covariance_reg;
    logic [15:0] speed_gain_reg;
    logic        enabled_reg;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg  <= AMPLITUDE_RST;
            cutoff_reg     <= CUTOFF_RST;
            covariance_reg <= COVARIANCE_RST;
            speed_gain_reg <= SPEED_GAIN_RST;
            enabled_reg    <= ENABLED_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (cfg_idx)
                REG_AMPLITUDE:  amplitude_reg  <= pwdata[7:0];
                REG_CUTOFF:     cutoff_reg     <= pwdata[7:0];
                REG_COVARIANCE: covariance_reg <= pwdata[15:0];
                REG_SPEED_GAIN: speed_gain_reg <= pwdata[15:0];
                REG_ENABLED:    enabled_reg    <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_AMPLITUDE:  prdata = DATA_W'(amplitude_reg);
            REG_CUTOFF:     prdata = DATA_W'(cutoff_reg);
            REG_COVARIANCE: prdata = DATA_W'(covariance_reg);
            REG_SPEED_GAIN: prdata = DATA_W'(speed_gain_reg);
            REG_ENABLED:    prdata = DATA_W'(enabled_reg);
            default:        prdata = '0;
        endcase
    end

    logic [COV_W-1:0] cov_eff;
    assign cov_eff = (covariance_reg == '0) ? COV_W'(1) : covariance_reg;

    // ------------------------------------------------------------------
    // Global pipeline enable
    // ------------------------------------------------------------------
    logic              en;
    logic              out_valid_reg;
    logic [COST_W-1:0] new_cost_reg;
    logic              written_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // ------------------------------------------------------------------
    // S0: capture request
    // ------------------------------------------------------------------
    logic                     v0_reg;
    logic signed [REL_W-1:0]  rx0_reg, ry0_reg;
    logic signed [VEL_W-1:0]  vx0_reg, vy0_reg;
    logic                     rel0_reg;
    logic [COST_W-1:0]        old0_reg;

    // S1: products
    logic                     v1_reg;
    logic                     rel1_reg;
    logic [COST_W-1:0]        old1_reg;
    logic                     ryn1_reg;
    logic [REL_W-1:0]         arx1_reg, ary1_reg;
    logic signed [SQ_W-1:0]   vxx1_reg, vyy1_reg;
    logic signed [PRJ_W-1:0]  pxy1_reg, pyx1_reg, qxx1_reg, qyy1_reg;
    logic signed [R2_W-1:0]   rxx1_reg, ryy1_reg;

    // S2: sums
    logic                     v2_reg;
    logic                     rel2_reg;
    logic [COST_W-1:0]        old2_reg;
    logic                     ryn2_reg;
    logic [REL_W-1:0]         arx2_reg, ary2_reg;
    logic [SQ_W-1:0]          s2_reg;
    logic signed [PRJ_W:0]    p2_reg, q2_reg;
    logic [R2_W-1:0]          r22_reg;

    // S3: magnitudes
    logic [SQ_W-1:0]          s3_reg;
    sqrt_ctx_t                c3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            c3_reg <= '0;
        end
        else if (en)
        begin
            v0_reg       <= in_valid;
            v1_reg       <= v0_reg;
            v2_reg       <= v1_reg;
            c3_reg.valid <= v2_reg;
            c3_reg.old   <= old2_reg;
            c3_reg.rel   <= rel2_reg;
            c3_reg.sz    <= (s2_reg == '0);
            c3_reg.pos   <= !p2_reg[PRJ_W] && (p2_reg != '0);
            c3_reg.ry_neg <= ryn2_reg;
            c3_reg.abs_rx <= arx2_reg;
            c3_reg.abs_ry <= ary2_reg;
            c3_reg.r2    <= r22_reg;
            c3_reg.ap    <= p2_reg[PRJ_W] ? PRJ_W'(-p2_reg) : PRJ_W'(p2_reg);
            c3_reg.aq    <= q2_reg[PRJ_W] ? PRJ_W'(-q2_reg) : PRJ_W'(q2_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx0_reg  <= rel_x;
            ry0_reg  <= rel_y;
            vx0_reg  <= vel_x;
            vy0_reg  <= vel_y;
            rel0_reg <= reliable;
            old0_reg <= prior_cost;

            rel1_reg <= rel0_reg;
            old1_reg <= old0_reg;
            ryn1_reg <= ry0_reg[REL_W-1];
            arx1_reg <= rx0_reg[REL_W-1] ? REL_W'(-rx0_reg) : REL_W'(rx0_reg);
            ary1_reg <= ry0_reg[REL_W-1] ? REL_W'(-ry0_reg) : REL_W'(ry0_reg);
            vxx1_reg <= SQ_W'(vx0_reg) * SQ_W'(vx0_reg);
            vyy1_reg <= SQ_W'(vy0_reg) * SQ_W'(vy0_reg);
            pxy1_reg <= PRJ_W'(PRJ_W'(rx0_reg) * PRJ_W'(vy0_reg));
            pyx1_reg <= PRJ_W'(PRJ_W'(ry0_reg) * PRJ_W'(vx0_reg));
            qxx1_reg <= PRJ_W'(PRJ_W'(rx0_reg) * PRJ_W'(vx0_reg));
            qyy1_reg <= PRJ_W'(PRJ_W'(ry0_reg) * PRJ_W'(vy0_reg));
            rxx1_reg <= R2_W'(R2_W'(rx0_reg) * R2_W'(rx0_reg));
            ryy1_reg <= R2_W'(R2_W'(ry0_reg) * R2_W'(ry0_reg));

            rel2_reg <= rel1_reg;
            old2_reg <= old1_reg;
            ryn2_reg <= ryn1_reg;
            arx2_reg <= arx1_reg;
            ary2_reg <= ary1_reg;
            s2_reg   <= SQ_W'(vxx1_reg) + SQ_W'(vyy1_reg);
            p2_reg   <= (PRJ_W+1)'(pxy1_reg) - (PRJ_W+1)'(pyx1_reg);
            q2_reg   <= (PRJ_W+1)'(qxx1_reg) + (PRJ_W+1)'(qyy1_reg);
            r22_reg  <= R2_W'(rxx1_reg) + R2_W'(ryy1_reg);

            s3_reg   <= s2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Speed by square root, then projections divided by speed
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] mag;
    sqrt_ctx_t        c4;
    proj_ctx_t        cp_in, cp_out;
    logic [AXIS_W-1:0] qp, qq;
    logic [R2_W-1:0]  r2_div;

    pcc_isqrt #(
        .SIDE_W ($bits(sqrt_ctx_t))
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .rad      (s3_reg),
        .side_in  (c3_reg),
        .root     (mag),
        .side_out (c4)
    );

    always_comb
    begin
        cp_in.valid  = c4.valid;
        cp_in.old    = c4.old;
        cp_in.rel    = c4.rel;
        cp_in.sz     = c4.sz;
        cp_in.pos    = c4.pos;
        cp_in.ry_neg = c4.ry_neg;
        cp_in.mag    = mag;
        cp_in.abs_rx = c4.abs_rx;
        cp_in.abs_ry = c4.abs_ry;
    end

    pcc_div #(
        .N_W    (PRJ_W),
        .D_W    (MAG_W),
        .Q_W    (AXIS_W),
        .SIDE_W ($bits(proj_ctx_t))
    ) u_div_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .num      (c4.ap),
        .den      (mag),
        .side_in  (cp_in),
        .quo      (qp),
        .side_out (cp_out)
    );

    pcc_div #(
        .N_W    (PRJ_W),
        .D_W    (MAG_W),
        .Q_W    (AXIS_W),
        .SIDE_W (R2_W)
    ) u_div_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .num      (c4.aq),
        .den      (mag),
        .side_in  (c4.r2),
        .quo      (qq),
        .side_out (r2_div)
    );

    // ------------------------------------------------------------------
    // X1..X5: axes, elongation, numerators and denominators
    // ------------------------------------------------------------------
    logic                v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic [COST_W-1:0]   old5_reg, old6_reg, old7_reg, old8_reg, old9_reg;
    logic [AXIS_W-1:0]   al5_reg, ac5_reg;
    logic                fr5_reg, sz5_reg, rel5_reg;
    logic [SQ_W-1:0]     g5_reg;
    logic [R2_W-1:0]     r25_reg;

    logic [AXSQ_W-1:0]   al26_reg, ac26_reg;
    logic [FA_W-1:0]     fa6_reg;
    logic                fr6_reg;
    logic [R2_W-1:0]     r26_reg;

    logic [NUMA_W-1:0]   na7_reg, na8_reg, na9_reg;
    logic [NUMB_W-1:0]   nb7_reg, nb8_reg, nb9_reg;
    logic [DENB_W-1:0]   db7_reg, db8_reg, db9_reg;
    logic [COV_W+FA_LO_W-1:0] pl7_reg, ph7_reg;
    logic [DENA_W-1:0]   da8_reg, da9_reg;
    logic                ova9_reg, ovb9_reg;

    logic [SQ_W+2:0]     g5x;
    logic [FA_W-1:0]     m_term;

    assign g5x    = (SQ_W+3)'({g5_reg, 2'b00}) + (SQ_W+3)'(g5_reg);
    assign m_term = rel5_reg ? FA_W'(g5_reg) : FA_W'(g5x >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= cp_out.valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            old5_reg <= cp_out.old;
            al5_reg  <= cp_out.sz ? AXIS_W'(cp_out.abs_ry) : qp;
            ac5_reg  <= cp_out.sz ? AXIS_W'(cp_out.abs_rx) : qq;
            fr5_reg  <= cp_out.sz ? cp_out.ry_neg : cp_out.pos;
            sz5_reg  <= cp_out.sz;
            rel5_reg <= cp_out.rel;
            g5_reg   <= SQ_W'(cp_out.mag) * SQ_W'(speed_gain_reg);
            r25_reg  <= r2_div;

            old6_reg <= old5_reg;
            al26_reg <= AXSQ_W'(al5_reg) * AXSQ_W'(al5_reg);
            ac26_reg <= AXSQ_W'(ac5_reg) * AXSQ_W'(ac5_reg);
            fa6_reg  <= FA_BASE + (sz5_reg ? '0 : m_term);
            fr6_reg  <= fr5_reg;
            r26_reg  <= r25_reg;

            old7_reg <= old6_reg;
            na7_reg  <= fr6_reg ? {al26_reg, 23'b0} : '0;
            nb7_reg  <= fr6_reg ? {ac26_reg, 15'b0} : NUMB_W'({r26_reg, 15'b0});
            db7_reg  <= {cov_eff, {FRAC_BITS{1'b0}}};
            pl7_reg  <= (COV_W+FA_LO_W)'(cov_eff) * (COV_W+FA_LO_W)'(fa6_reg[FA_LO_W-1:0]);
            ph7_reg  <= (COV_W+FA_LO_W)'(cov_eff)
                        * (COV_W+FA_LO_W)'(fa6_reg[FA_W-1:FA_LO_W]);

            old8_reg <= old7_reg;
            na8_reg  <= na7_reg;
            nb8_reg  <= nb7_reg;
            db8_reg  <= db7_reg;
            da8_reg  <= DENA_W'(pl7_reg) + (DENA_W'(ph7_reg) << FA_LO_W);

            old9_reg <= old8_reg;
            na9_reg  <= na8_reg;
            nb9_reg  <= nb8_reg;
            db9_reg  <= db8_reg;
            da9_reg  <= da8_reg;
            ova9_reg <= CMPA_W'(na8_reg) >= {da8_reg, {EQ_W{1'b0}}};
            ovb9_reg <= CMPB_W'(nb8_reg) >= CMPB_W'({db8_reg, {EQ_W{1'b0}}});
        end
    end

    // ------------------------------------------------------------------
    // Exponent quotients
    // ------------------------------------------------------------------
    expo_ctx_t         ce_in, ce_out;
    logic [EQ_W-1:0]   qa, qb;
    logic              ovb_div;

    always_comb
    begin
        ce_in.valid = v9_reg;
        ce_in.old   = old9_reg;
        ce_in.ova   = ova9_reg;
    end

    pcc_div #(
        .N_W    (NUMA_W),
        .D_W    (DENA_W),
        .Q_W    (EQ_W),
        .SIDE_W ($bits(expo_ctx_t))
    ) u_div_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .num      (na9_reg),
        .den      (da9_reg),
        .side_in  (ce_in),
        .quo      (qa),
        .side_out (ce_out)
    );

    pcc_div #(
        .N_W    (NUMB_W),
        .D_W    (DENB_W),
        .Q_W    (EQ_W),
        .SIDE_W (1)
    ) u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .num      (nb9_reg),
        .den      (db9_reg),
        .side_in  (ovb9_reg),
        .quo      (qb),
        .side_out (ovb_div)
    );

    logic [E_W-1:0]    e_sum;
    logic [E_W-1:0]    e10_reg;
    tail_ctx_t         ct10_reg;

    assign e_sum = E_W'(qa) + E_W'(qb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ct10_reg <= '0;
        end
        else if (en)
        begin
            ct10_reg.valid <= ce_out.valid;
            ct10_reg.old   <= ce_out.old;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ce_out.ova || ovb_div || (e_sum > E_LIMIT))
            begin
                e10_reg <= E_LIMIT;
            end
            else
            begin
                e10_reg <= e_sum;
            end
        end
    end

    // ------------------------------------------------------------------
    // Exponential and result
    // ------------------------------------------------------------------
    logic [COST_W-1:0] cost;
    tail_ctx_t         ct_out;
    logic              active;

    pcc_exp #(
        .SIDE_W ($bits(tail_ctx_t))
    ) u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .e        (e10_reg),
        .amp      (amplitude_reg),
        .side_in  (ct10_reg),
        .cost     (cost),
        .side_out (ct_out)
    );

    assign active = enabled_reg && (cutoff_reg < amplitude_reg)
                    && (ct_out.old != COST_UNKNOWN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ct_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (active && (cost >= cutoff_reg))
            begin
                new_cost_reg <= (cost > ct_out.old) ? cost : ct_out.old;
                written_reg  <= 1'b1;
            end
            else
            begin
                new_cost_reg <= ct_out.old;
                written_reg  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign new_cost  = new_cost_reg;
    assign written   = written_reg;

endmodule
